@@ rtl/fbc_pkg.sv @@
// Package with the shared types, widths and constants of the Feistel block cipher unit.
package fbc_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 64;
  localparam int HALF_W  = 32;
  localparam int KEY_W   = 48;
  localparam int RC_W    = 5;
  localparam int PERM_N  = 64;
  localparam int SBOX_N  = 64;
  localparam int SBOX_W  = 4;
  localparam int GROUP_N = 8;
  localparam int GROUP_W = 6;
  localparam int QDEPTH  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_PERM = 2'd0,
    OP_LOAD_KEY  = 2'd1,
    OP_LOAD_SBOX = 2'd2,
    OP_PROCESS   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADDR,
    BK_DATA,
    BK_FINAL
  } bk_state_t;

  // DES expansion: expanded bit i is taken from half-block bit EXP_TAB[i].
  localparam logic [4:0] EXP_TAB [0:KEY_W-1] = '{
    5'd31, 5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,
    5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
    5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24,
    5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd0
  };

endpackage

@@ rtl/fbc_if.sv @@
// Handshake interfaces for the input and result channels.
interface fbc_in_if;
  logic                         valid;
  logic                         ready;
  logic [fbc_pkg::OP_W-1:0]     op;
  logic [fbc_pkg::IDX_W-1:0]    index;
  logic [fbc_pkg::DATA_W-1:0]   data_word;

  modport source (output valid, output op, output index, output data_word, input ready);
  modport sink   (input valid, input op, input index, input data_word, output ready);
endinterface

interface fbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fbc_pkg::DATA_W-1:0]   result_block;

  modport source (output valid, output result_block, input ready);
  modport sink   (input valid, input result_block, output ready);
endinterface

@@ rtl/fbc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module fbc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fbc_front.sv @@
// Front end: takes input beats, decodes the operation and queues commands for the back end.
module fbc_front #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  fbc_in_if.sink        in_ch,
  output fbc_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);

  localparam int PTR_W = (fbc_pkg::QDEPTH > 1) ? $clog2(fbc_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(fbc_pkg::QDEPTH + 1);

  fbc_pkg::cmd_t    slot_r [fbc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  fbc_pkg::cmd_t    in_cmd;
  logic             accept, drop, push, pop;

  always_comb begin
    in_cmd.op    = fbc_pkg::op_t'(in_ch.op);
    in_cmd.index = in_ch.index;
    in_cmd.data  = in_ch.data_word;
  end

  assign in_ch.ready = (count_r != CNT_W'(fbc_pkg::QDEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  // A key load beyond the last round key has no effect, so it never enters the queue.
  assign drop = (in_cmd.op == fbc_pkg::OP_LOAD_KEY) &&
                (in_cmd.index >= fbc_pkg::IDX_W'(MAX_ROUNDS));
  assign push = accept && !drop;

  assign cmd_valid = (count_r != '0);
  assign cmd       = slot_r[rd_ptr_r];
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(fbc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(fbc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

@@ rtl/fbc_back.sv @@
// Back end: holds the tables, applies loads and runs the permutations and Feistel rounds.
module fbc_back #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbc_pkg::cmd_t                cmd,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [fbc_pkg::RC_W-1:0]     round_count,
  fbc_out_if.source                    out_ch
);

  localparam int KEY_AW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int SB_AW  = $clog2(fbc_pkg::SBOX_N);

  fbc_pkg::bk_state_t state_r, state_nxt;
  logic [fbc_pkg::RC_W-1:0]   rnd_r, rnd_nxt;
  logic [fbc_pkg::RC_W-1:0]   n_rounds;
  logic [fbc_pkg::HALF_W-1:0] l_r, l_nxt, r_r, r_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [fbc_pkg::DATA_W-1:0] out_data_r, out_data_nxt;

  logic [fbc_pkg::IDX_W-1:0]  perm_r [fbc_pkg::PERM_N];
  logic [fbc_pkg::IDX_W-1:0]  inv_r  [fbc_pkg::PERM_N];
  logic [fbc_pkg::KEY_W-1:0]  key_r  [MAX_ROUNDS];

  logic                       take;
  logic [fbc_pkg::DATA_W-1:0] perm_blk, swap_blk, inv_blk;
  logic [fbc_pkg::KEY_W-1:0]  exp_x;
  logic [fbc_pkg::HALF_W-1:0] f_val;
  logic                       sb_we;
  logic [SB_AW-1:0]           sb_raddr [fbc_pkg::GROUP_N];
  logic [fbc_pkg::SBOX_W-1:0] sb_rdata [fbc_pkg::GROUP_N];

  assign n_rounds  = (round_count > fbc_pkg::RC_W'(MAX_ROUNDS)) ?
                     fbc_pkg::RC_W'(MAX_ROUNDS) : round_count;
  assign cmd_ready = (state_r == fbc_pkg::BK_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign sb_we     = take && (cmd.op == fbc_pkg::OP_LOAD_SBOX);

  // Initial permutation straight from the queued block; final swap and inverse permutation.
  always_comb begin
    swap_blk = {l_r, r_r};
    for (int i = 0; i < fbc_pkg::PERM_N; i++) begin
      perm_blk[i] = cmd.data[perm_r[i]];
      inv_blk[i]  = swap_blk[inv_r[i]];
    end
  end

  // Round function: expansion and key mix, then one shared S-box copy per group.
  always_comb begin
    for (int i = 0; i < fbc_pkg::KEY_W; i++) begin
      exp_x[i] = r_r[fbc_pkg::EXP_TAB[i]];
    end
    exp_x = exp_x ^ key_r[rnd_r[KEY_AW-1:0]];
    for (int c = 0; c < fbc_pkg::GROUP_N; c++) begin
      sb_raddr[c] = {exp_x[c*fbc_pkg::GROUP_W + 5], exp_x[c*fbc_pkg::GROUP_W],
                     exp_x[c*fbc_pkg::GROUP_W + 1 +: 4]};
      f_val[c*fbc_pkg::SBOX_W +: fbc_pkg::SBOX_W] = sb_rdata[c];
    end
  end

  for (genvar g = 0; g < fbc_pkg::GROUP_N; g++) begin : g_sbox
    fbc_ram #(
      .WIDTH (fbc_pkg::SBOX_W),
      .DEPTH (fbc_pkg::SBOX_N)
    ) u_sbox (
      .clk   (clk),
      .we    (sb_we),
      .waddr (cmd.index),
      .wdata (cmd.data[fbc_pkg::SBOX_W-1:0]),
      .raddr (sb_raddr[g]),
      .rdata (sb_rdata[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      fbc_pkg::BK_IDLE: begin
        if (take && (cmd.op == fbc_pkg::OP_PROCESS)) begin
          l_nxt     = perm_blk[fbc_pkg::HALF_W-1:0];
          r_nxt     = perm_blk[fbc_pkg::DATA_W-1:fbc_pkg::HALF_W];
          rnd_nxt   = '0;
          state_nxt = (n_rounds == '0) ? fbc_pkg::BK_FINAL : fbc_pkg::BK_ADDR;
        end
      end
      fbc_pkg::BK_ADDR: begin
        state_nxt = fbc_pkg::BK_DATA;
      end
      fbc_pkg::BK_DATA: begin
        l_nxt     = r_r;
        r_nxt     = l_r ^ f_val;
        rnd_nxt   = rnd_r + 1'b1;
        state_nxt = (rnd_nxt == n_rounds) ? fbc_pkg::BK_FINAL : fbc_pkg::BK_ADDR;
      end
      fbc_pkg::BK_FINAL: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = inv_blk;
          state_nxt     = fbc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = fbc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbc_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    out_data_r <= out_data_nxt;
    if (take && (cmd.op == fbc_pkg::OP_LOAD_PERM)) begin
      perm_r[cmd.index]                   <= cmd.data[fbc_pkg::IDX_W-1:0];
      inv_r[cmd.data[fbc_pkg::IDX_W-1:0]] <= cmd.index;
    end
    if (take && (cmd.op == fbc_pkg::OP_LOAD_KEY)) begin
      key_r[cmd.index[KEY_AW-1:0]] <= cmd.data[fbc_pkg::KEY_W-1:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_block = out_data_r;

endmodule

@@ rtl/feistel_block_cipher_unit.sv @@
// Each round of a block runs through an address state and a data state, because the
// S-box RAMs have a registered read; the back end takes no further command until the
// block has left its final state, and it applies each table load as it accepts it.
// Reset: synchronous, active low; clears the queue, the control state and sets round_count
// to MAX_ROUNDS. The loadable tables are not cleared and must be loaded before use.
module feistel_block_cipher_unit #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  fbc_in_if.sink                   in_ch,
  fbc_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [fbc_pkg::RC_W-1:0] cfg_wdata
);

  // The single configuration register: the number of Feistel rounds per block.
  // Values above MAX_ROUNDS are clamped in the back end.
  logic [fbc_pkg::RC_W-1:0] round_count_r, round_count_nxt;

  // Command path from the front end queue to the back end.
  fbc_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_ready;

  assign round_count_nxt = cfg_we ? cfg_wdata : round_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= fbc_pkg::RC_W'(MAX_ROUNDS);
    end else begin
      round_count_r <= round_count_nxt;
    end
  end

  // The front end takes each beat, decodes its operation, discards key loads that
  // address no key slot, and queues the rest in order. Until both queue slots are full,
  // this keeps the input side moving while the back end works through a block's rounds.
  fbc_front #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // The back end applies table loads in queue order, so a load never overtakes a
  // block that was sent before it. Blocks go through the initial permutation, the
  // rounds, the half swap and the inverse permutation into an output register, which
  // lets further loads proceed while a result waits to be taken.
  fbc_back #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .round_count (round_count_r),
    .out_ch      (out_ch)
  );

endmodule

@@ tb/feistel_tb_pkg.sv @@
// Scoreboard class that predicts and checks the cipher unit's result blocks.
`timescale 1ns / 100ps

package feistel_tb_pkg;
  import fbc_pkg::*;

  localparam int KEY_SLOTS = 16;

  class cipher_scoreboard;
    logic [IDX_W-1:0]  perm_map  [PERM_N];
    logic [IDX_W-1:0]  inv_map   [PERM_N];
    logic [KEY_W-1:0]  key_sched [KEY_SLOTS];
    logic [SBOX_W-1:0] sbox_map  [SBOX_N];
    logic [RC_W-1:0]   round_count;
    logic [DATA_W-1:0] expected_blocks [$];
    int                errors;

    function new();
      round_count = RC_W'(KEY_SLOTS);
      errors      = 0;
    endfunction

    function void set_round_count(logic [RC_W-1:0] value);
      round_count = value;
    endfunction

    // Round function: expansion, key mix and the shared S-box in all eight groups.
    function logic [HALF_W-1:0] mix_half(logic [HALF_W-1:0] rh, logic [KEY_W-1:0] key);
      logic [KEY_W-1:0]   x;
      logic [GROUP_W-1:0] g;
      logic [HALF_W-1:0]  res;
      // Group c of the expansion reads half bits 4c-1 .. 4c+4, wrapping around.
      for (int c = 0; c < GROUP_N; c++)
        for (int j = 0; j < GROUP_W; j++)
          x[GROUP_W*c+j] = rh[(4*c + j + HALF_W - 1) % HALF_W];
      x   = x ^ key;
      res = '0;
      for (int c = 0; c < GROUP_N; c++) begin
        g = x[GROUP_W*c +: GROUP_W];
        res[SBOX_W*c +: SBOX_W] = sbox_map[{g[5], g[0], g[4:1]}];
      end
      return res;
    endfunction

    function logic [DATA_W-1:0] encipher_block(logic [DATA_W-1:0] plain);
      logic [DATA_W-1:0] mixed;
      logic [DATA_W-1:0] cipher;
      logic [HALF_W-1:0] lh;
      logic [HALF_W-1:0] rh;
      logic [HALF_W-1:0] t;
      int                n;
      for (int i = 0; i < PERM_N; i++) mixed[i] = plain[perm_map[i]];
      lh = mixed[HALF_W-1:0];
      rh = mixed[DATA_W-1:HALF_W];
      n  = (round_count > KEY_SLOTS) ? KEY_SLOTS : int'(round_count);
      for (int r = 0; r < n; r++) begin
        t  = lh;
        lh = rh;
        rh = t ^ mix_half(rh, key_sched[r]);
      end
      mixed = {lh, rh};
      for (int i = 0; i < PERM_N; i++) cipher[i] = mixed[inv_map[i]];
      return cipher;
    endfunction

    function void note_input(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (op)
        OP_LOAD_PERM: begin
          perm_map[idx]              = data[IDX_W-1:0];
          inv_map[data[IDX_W-1:0]]   = idx;
        end
        OP_LOAD_KEY: begin
          if (idx < KEY_SLOTS) key_sched[idx] = data[KEY_W-1:0];
        end
        OP_LOAD_SBOX: sbox_map[idx] = data[SBOX_W-1:0];
        default: expected_blocks.push_back(encipher_block(data));
      endcase
    endfunction

    function void check_result(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] want;
      if (expected_blocks.size() == 0) begin
        $error("result_block: none expected, actual %h", actual);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (actual !== want) begin
        $error("result_block: expected %h, actual %h", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

endpackage

@@ tb/feistel_block_cipher_unit_tb.sv @@
// Testbench top: drives table loads and blocks into the cipher unit and checks every result.
`timescale 1ns / 100ps

module feistel_block_cipher_unit_tb;
  import fbc_pkg::*;
  import feistel_tb_pkg::*;

  localparam int ROUNDS_MAX       = 16;
  // Settle time, sized from a block at the maximum round count plus margin for queued table loads.
  localparam int SETTLE_CYCLES    = 2 * ROUNDS_MAX + 3 + 8;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 82;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [RC_W-1:0]  cfg_wdata;

  fbc_in_if  in_ch ();
  fbc_out_if out_ch ();

  feistel_block_cipher_unit #(
    .MAX_ROUNDS(ROUNDS_MAX)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  cipher_scoreboard sb = new();

  // Beats still allowed before the sender takes its next random gap.
  int burst_left = 0;

  // Receiver stall pattern state.
  int stall_mode  = 0;
  int stall_count = 0;
  int stall_tick  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send one beat. The sender works in bursts: when the current burst is used up it
  // drops valid for a random gap, then starts a new burst of random length. Long
  // bursts now and then give stretches with no idling at all. Every assignment happens
  // right after a rising edge, and the handshake is judged on the values that held
  // just before that edge, so nothing depends on event order within a time step.
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.index     <= idx;
    in_ch.data_word <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, idx, data);
  endtask

  // Stop sending and wait until every expected block has arrived. Table loads have no
  // result, so a fixed settle time follows to let any load still in flight finish.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The round count register is only written while the unit is idle.
  task automatic write_round_count(logic [RC_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_round_count(value);
  endtask

  // Fill every table entry: a fresh random permutation (so its inverse is complete),
  // all sixteen round keys and all 64 S-box cells. The upper data bits that the unit
  // ignores carry random junk.
  task automatic load_tables();
    logic [IDX_W-1:0]  order [PERM_N];
    logic [IDX_W-1:0]  tmp;
    logic [DATA_W-1:0] word;
    int                j;
    for (int i = 0; i < PERM_N; i++) order[i] = IDX_W'(i);
    for (int i = PERM_N - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < PERM_N; i++) begin
      word        = {$urandom, $urandom};
      word[IDX_W-1:0] = order[i];
      send_item(OP_LOAD_PERM, IDX_W'(i), word);
    end
    for (int i = 0; i < KEY_SLOTS; i++)
      send_item(OP_LOAD_KEY, IDX_W'(i), {$urandom, $urandom});
    for (int i = 0; i < SBOX_N; i++)
      send_item(OP_LOAD_SBOX, IDX_W'(i), {$urandom, $urandom});
  endtask

  // Exchange two permutation entries; the table stays a permutation and the inverse
  // follows both writes.
  task automatic swap_perm(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] va;
    logic [IDX_W-1:0] vb;
    va = sb.perm_map[a];
    vb = sb.perm_map[b];
    send_item(OP_LOAD_PERM, a, {{(DATA_W-IDX_W){1'b1}}, vb});
    send_item(OP_LOAD_PERM, b, {{(DATA_W-IDX_W){1'b0}}, va});
  endtask

  // One random action. Mostly blocks with random content, with table updates mixed
  // in so that later blocks see changed keys, S-box cells and permutation entries.
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      send_item(OP_PROCESS, IDX_W'($urandom), {$urandom, $urandom});
    end else if (pick < 80) begin
      send_item(OP_LOAD_SBOX, IDX_W'($urandom), {$urandom, $urandom});
    end else if (pick < 88) begin
      // A quarter of the key loads aim past the last key slot and must be ignored.
      if ($urandom_range(0, 3) == 0)
        send_item(OP_LOAD_KEY, IDX_W'($urandom_range(KEY_SLOTS, 63)), {$urandom, $urandom});
      else
        send_item(OP_LOAD_KEY, IDX_W'($urandom_range(0, KEY_SLOTS - 1)),
                  {$urandom, $urandom});
    end else if (pick < 97) begin
      swap_perm(IDX_W'($urandom), IDX_W'($urandom));
    end else begin
      // A lone entry breaks the permutation; stale inverse entries stay in use.
      send_item(OP_LOAD_PERM, IDX_W'($urandom), {$urandom, $urandom});
    end
  endtask

  // Receiver: at every edge take the beat on offer, then pick the next ready value.
  // The pattern switches now and then between always ready, coin-flip ready and
  // ready only one cycle in four.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.result_block);
    if (stall_count == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_count = $urandom_range(16, 96);
    end
    stall_count--;
    stall_tick++;
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ch.ready <= (stall_tick % 4 == 0);
      end
    endcase
  end

  // Main sequence.
  initial begin
    logic [RC_W-1:0]  phase_rounds [PHASES];
    logic [IDX_W-1:0] v1;
    logic [IDX_W-1:0] v2;
    phase_rounds    = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd8, 5'd16};
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.op        = '0;
    in_ch.index     = '0;
    in_ch.data_word = '0;
    out_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The tables come up undefined, so everything is loaded before the first block.
    load_tables();

    // Directed blocks at the reset round count of sixteen: data extremes first.
    send_item(OP_PROCESS, '0, '0);
    send_item(OP_PROCESS, '1, '1);
    send_item(OP_PROCESS, '0, 64'h8000_0000_0000_0001);
    send_item(OP_PROCESS, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_PROCESS, '0, 64'h5555_5555_5555_5555);

    // Key loads past the last slot leave every key unchanged.
    send_item(OP_LOAD_KEY, IDX_W'(KEY_SLOTS), '1);
    send_item(OP_LOAD_KEY, '1, '1);
    send_item(OP_PROCESS, '0, {$urandom, $urandom});

    // Key and S-box extremes; only the low bits of the data word count.
    send_item(OP_LOAD_KEY, IDX_W'(KEY_SLOTS - 1), '1);
    send_item(OP_LOAD_KEY, '0, '0);
    send_item(OP_LOAD_SBOX, '1, '1);
    send_item(OP_LOAD_SBOX, '0, 64'hFFFF_FFFF_FFFF_FFF0);
    send_item(OP_PROCESS, '0, {$urandom, $urandom});

    // Swap the first and last permutation entries.
    swap_perm('0, '1);
    send_item(OP_PROCESS, '0, {$urandom, $urandom});

    // Make the permutation a non-permutation: entry 1 copies entry 2, so the inverse
    // for that value now points at 1. Then repair both entries in turn.
    v1 = sb.perm_map[1];
    v2 = sb.perm_map[2];
    send_item(OP_LOAD_PERM, 6'd1, {{(DATA_W-IDX_W){1'b1}}, v2});
    send_item(OP_PROCESS, '0, {$urandom, $urandom});
    send_item(OP_LOAD_PERM, 6'd1, {{(DATA_W-IDX_W){1'b0}}, v1});
    send_item(OP_PROCESS, '0, {$urandom, $urandom});
    send_item(OP_LOAD_PERM, 6'd2, {{(DATA_W-IDX_W){1'b0}}, v2});
    send_item(OP_PROCESS, '0, {$urandom, $urandom});

    // Random phases, each at its own round count: zero rounds, one round, counts above
    // the maximum (which clamp to sixteen), a middle value and the maximum itself.
    // Each config write waits for the pipeline to run dry first.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == 4) write_round_count(RC_W'($urandom_range(2, 15)));
      else write_round_count(phase_rounds[p]);
      if (p == 3) load_tables();
      for (int k = 0; k < RANDOM_PER_PHASE; k++) random_item();
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
